[sv/pqd_pkg.sv]
// shared constants, types and widths for the packed quaternion decoder
package pqd_pkg;

	// fixed point fraction bits of every output component
	localparam int FRAC_BITS = 14;
	// result bits of one square root unit (values 0 .. 2^FRAC_BITS)
	localparam int QB = FRAC_BITS + 1;
	// width of a sum of three scaled squares
	localparam int DW = 40;
	// remainder and step arithmetic width of the root units
	localparam int AW = DW + 2 * FRAC_BITS + 6;
	// width of the running den*(2q-1) term
	localparam int PW = DW + FRAC_BITS + 3;
	// rounding dividends for the x/y and z quotients
	localparam int XAW = FRAC_BITS + 11;
	localparam int ZAW = FRAC_BITS + 10;
	// reciprocal scale and reciprocal widths
	localparam int RK = FRAC_BITS + 11;
	localparam int MXW = RK - 9;
	localparam int MZW = RK - 8;
	localparam logic [MXW-1:0] RECIP_XY = MXW'((64'd1 << RK) / 64'd1023);
	localparam logic [MZW-1:0] RECIP_Z = MZW'((64'd1 << RK) / 64'd511);
	// quotient width of the direct path
	localparam int QDW = FRAC_BITS + 2;
	// pipeline stage counts
	localparam int FRONT_ST = 6;
	localparam int NST = FRONT_ST + QB + 1;
	// scale constants: (1023*511)^2, 511^2, 1023^2
	localparam logic [DW-1:0] DEN_SQ = DW'(64'd522753 * 64'd522753);
	localparam logic [17:0] XY_SCALE_SQ = 18'd261121;
	localparam logic [19:0] Z_SCALE_SQ = 20'd1046529;
	// full scale value of one component
	localparam logic [QDW-1:0] ONE_FX = QDW'(64'd1 << FRAC_BITS);

	// starting point of one square root unit
	typedef struct packed {
		logic signed [AW-1:0] rem;
		logic signed [PW-1:0] par;
		logic [DW-1:0]        den;
	} root_in_t;

	// per item data that travels beside the root units
	typedef struct packed {
		logic [31:0]    key_time;
		logic           last;
		logic           norm;
		logic           neg_x;
		logic           neg_y;
		logic           neg_z;
		logic [QDW-1:0] qx;
		logic [QDW-1:0] qy;
		logic [QDW-1:0] qz;
	} side_t;

	// handshake and stage enables from the pipeline control
	typedef struct packed {
		logic           in_ready;
		logic [NST-1:0] en;
		logic           out_valid;
	} pipe_ctrl_t;

endpackage

[sv/packed_quaternion_decoder_top.sv]
// top level of the packed quaternion decoder
//
// Decodes one 11/11/10 packed orientation key per clock into a Q1.14
// quaternion (x, y, z, w), passing the key time bits and the last marker
// through. The pipeline holds six stages of unpacking, squaring,
// reciprocal division and setup, fifteen stages of the three square root
// pipelines (one result bit per stage, one unit shared between x and w),
// and the output register. One item is accepted per cycle whenever the
// output is taken; valid bits travel with each stage, so bubbles are
// squeezed out and a stalled output still lets empty stages fill.
module packed_quaternion_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] packed_word, [63:32] key_time_bits
	input  logic [63:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] quat_x, [31:16] quat_y, [47:32] quat_z, [62:48] quat_w,
	// [94:63] key_time_out, [95] zero
	output logic [95:0] m_axis_tdata,
	// [0] was_normalized
	output logic [0:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam int RST = pqd_pkg::FRONT_ST;

	pqd_pkg::pipe_ctrl_t    ctl;
	pqd_pkg::root_in_t      root_a, root_b, root_c;
	pqd_pkg::side_t         side_f;
	pqd_pkg::side_t         side_s [pqd_pkg::QB];
	logic [pqd_pkg::QB-1:0] ra, rb, rc;

	logic [pqd_pkg::QDW-1:0] mag_x, mag_y, mag_z, mag_w;
	logic [pqd_pkg::QDW-1:0] cl_x, cl_y, cl_z, cl_w;

	logic [15:0] qx_q, qy_q, qz_q;
	logic [14:0] qw_q;
	logic [31:0] time_q;
	logic        norm_q, last_q;

	// stage control
	pqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	// unpack and setup stages
	pqd_front u_front (
		.clk           (clk),
		.en            (ctl.en[RST-1:0]),
		.packed_word   (s_axis_tdata[31:0]),
		.key_time_bits (s_axis_tdata[63:32]),
		.last_in       (s_axis_tlast),
		.root_a        (root_a),
		.root_b        (root_b),
		.root_c        (root_c),
		.side          (side_f)
	);

	// root units: x or w, y, z
	pqd_root u_root_a (
		.clk     (clk),
		.en      (ctl.en[RST +: pqd_pkg::QB]),
		.root_in (root_a),
		.root_q  (ra)
	);

	pqd_root u_root_b (
		.clk     (clk),
		.en      (ctl.en[RST +: pqd_pkg::QB]),
		.root_in (root_b),
		.root_q  (rb)
	);

	pqd_root u_root_c (
		.clk     (clk),
		.en      (ctl.en[RST +: pqd_pkg::QB]),
		.root_in (root_c),
		.root_q  (rc)
	);

	// side data delayed alongside the root stages
	for (genvar k = 0; k < pqd_pkg::QB; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (ctl.en[RST + k]) begin
				side_s[k] <= (k == 0) ? side_f : side_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	// pick the component source and clamp to full scale
	assign mag_x = side_s[pqd_pkg::QB-1].norm ? pqd_pkg::QDW'(ra) : side_s[pqd_pkg::QB-1].qx;
	assign mag_y = side_s[pqd_pkg::QB-1].norm ? pqd_pkg::QDW'(rb) : side_s[pqd_pkg::QB-1].qy;
	assign mag_z = side_s[pqd_pkg::QB-1].norm ? pqd_pkg::QDW'(rc) : side_s[pqd_pkg::QB-1].qz;
	assign mag_w = side_s[pqd_pkg::QB-1].norm ? '0 : pqd_pkg::QDW'(ra);

	assign cl_x = (mag_x > pqd_pkg::ONE_FX) ? pqd_pkg::ONE_FX : mag_x;
	assign cl_y = (mag_y > pqd_pkg::ONE_FX) ? pqd_pkg::ONE_FX : mag_y;
	assign cl_z = (mag_z > pqd_pkg::ONE_FX) ? pqd_pkg::ONE_FX : mag_z;
	assign cl_w = (mag_w > pqd_pkg::ONE_FX) ? pqd_pkg::ONE_FX : mag_w;

	// output register
	always_ff @(posedge clk) begin
		if (ctl.en[pqd_pkg::NST-1]) begin
			qx_q   <= side_s[pqd_pkg::QB-1].neg_x ? 16'd0 - 16'(cl_x) : 16'(cl_x);
			qy_q   <= side_s[pqd_pkg::QB-1].neg_y ? 16'd0 - 16'(cl_y) : 16'(cl_y);
			qz_q   <= side_s[pqd_pkg::QB-1].neg_z ? 16'd0 - 16'(cl_z) : 16'(cl_z);
			qw_q   <= 15'd0 - 15'(cl_w);
			time_q <= side_s[pqd_pkg::QB-1].key_time;
			norm_q <= side_s[pqd_pkg::QB-1].norm;
			last_q <= side_s[pqd_pkg::QB-1].last;
		end
	end

	assign s_axis_tready = ctl.in_ready;
	assign m_axis_tvalid = ctl.out_valid;
	assign m_axis_tdata  = {1'b0, time_q, qw_q, qz_q, qy_q, qx_q};
	assign m_axis_tuser  = norm_q;
	assign m_axis_tlast  = last_q;

endmodule

[sv/pqd_ctrl.sv]
// valid bits and per-stage load enables of the decoder pipeline
module pqd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_ready,
	output pqd_pkg::pipe_ctrl_t ctl
);

	logic [pqd_pkg::NST-1:0] valid_q;
	logic [pqd_pkg::NST:0]   rdy;
	logic [pqd_pkg::NST-1:0] vin;

	// a stage may load when it is empty or its successor takes its item
	assign rdy[pqd_pkg::NST] = out_ready;
	for (genvar k = 0; k < pqd_pkg::NST; k++) begin : g_rdy
		assign rdy[k] = !valid_q[k] || rdy[k+1];
	end

	assign vin = {valid_q[pqd_pkg::NST-2:0], in_valid};

	// valid bits move with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (rdy[pqd_pkg::NST-1:0] & vin) | (~rdy[pqd_pkg::NST-1:0] & valid_q);
		end
	end

	assign ctl.in_ready  = rdy[0];
	assign ctl.en        = rdy[pqd_pkg::NST-1:0];
	assign ctl.out_valid = valid_q[pqd_pkg::NST-1];

endmodule

[sv/pqd_front.sv]
// unpack, squares, direct quotients and root unit setup (six stages)
module pqd_front (
	input  logic                         clk,
	input  logic [pqd_pkg::FRONT_ST-1:0] en,
	input  logic [31:0]                  packed_word,
	input  logic [31:0]                  key_time_bits,
	input  logic                         last_in,
	output pqd_pkg::root_in_t            root_a,
	output pqd_pkg::root_in_t            root_b,
	output pqd_pkg::root_in_t            root_c,
	output pqd_pkg::side_t               side
);

	typedef struct packed {
		logic [31:0] key_time;
		logic        last;
		logic        neg_x;
		logic        neg_y;
		logic        neg_z;
	} carry_t;

	localparam int SH = 2 * pqd_pkg::FRAC_BITS + 2;
	localparam int XPW = pqd_pkg::XAW + pqd_pkg::MXW;
	localparam int ZPW = pqd_pkg::ZAW + pqd_pkg::MZW;

	// stage 1
	logic signed [11:0] dx_s1, dy_s1;
	logic signed [10:0] dz_s1;
	carry_t             cr_s1;
	// stage 2
	logic [20:0]              sqx_s2, sqy_s2;
	logic [18:0]              sqz_s2;
	logic [pqd_pkg::XAW-1:0]  nx_s2, ny_s2;
	logic [pqd_pkg::ZAW-1:0]  nz_s2;
	carry_t                   cr_s2;
	// stage 3
	logic [pqd_pkg::DW-1:0]   sx_s3, sy_s3, sz_s3;
	logic [XPW-1:0]           mx_s3, my_s3;
	logic [ZPW-1:0]           mz_s3;
	logic [pqd_pkg::XAW-1:0]  nx_s3, ny_s3;
	logic [pqd_pkg::ZAW-1:0]  nz_s3;
	carry_t                   cr_s3;
	// stage 4
	logic [pqd_pkg::DW-1:0]   sx_s4, sy_s4, sz_s4, sum_s4;
	logic [pqd_pkg::QDW-1:0]  q0x_s4, q0y_s4, q0z_s4;
	logic [pqd_pkg::XAW-1:0]  nx_s4, ny_s4;
	logic [pqd_pkg::ZAW-1:0]  nz_s4;
	carry_t                   cr_s4;
	// stage 5
	logic [pqd_pkg::DW-1:0]   sx_s5, sy_s5, sz_s5, sum_s5, diff_s5;
	logic                     norm_s5;
	logic [pqd_pkg::QDW-1:0]  qx_s5, qy_s5, qz_s5;
	carry_t                   cr_s5;
	// stage 6
	pqd_pkg::root_in_t        ra_s6, rb_s6, rc_s6;
	pqd_pkg::side_t           side_s6;

	logic signed [23:0]       sqx_full, sqy_full;
	logic signed [21:0]       sqz_full;
	logic [10:0]              ax, ay;
	logic [9:0]               az;
	logic [pqd_pkg::XAW:0]    remx, remy;
	logic [pqd_pkg::ZAW:0]    remz;
	logic [pqd_pkg::DW-1:0]   num_a, den_a;

	// stage 1: signed offsets of the three fields, signs from the field top bits
	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1          <= 12'sd1023 - $signed({1'b0, packed_word[10:0]});
			dy_s1          <= 12'sd1023 - $signed({1'b0, packed_word[21:11]});
			dz_s1          <= 11'sd511 - $signed({1'b0, packed_word[31:22]});
			cr_s1.key_time <= key_time_bits;
			cr_s1.last     <= last_in;
			cr_s1.neg_x    <= packed_word[10];
			cr_s1.neg_y    <= packed_word[21];
			cr_s1.neg_z    <= packed_word[31];
		end
	end

	// stage 2: squares, magnitudes and rounding dividends
	assign sqx_full = dx_s1 * dx_s1;
	assign sqy_full = dy_s1 * dy_s1;
	assign sqz_full = dz_s1 * dz_s1;
	assign ax = dx_s1[11] ? 11'(-dx_s1) : 11'(dx_s1);
	assign ay = dy_s1[11] ? 11'(-dy_s1) : 11'(dy_s1);
	assign az = dz_s1[10] ? 10'(-dz_s1) : 10'(dz_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sqx_s2      <= sqx_full[20:0];
			sqy_s2      <= sqy_full[20:0];
			sqz_s2      <= sqz_full[18:0];
			nx_s2       <= (pqd_pkg::XAW'(ax) << pqd_pkg::FRAC_BITS) + pqd_pkg::XAW'(511);
			ny_s2       <= (pqd_pkg::XAW'(ay) << pqd_pkg::FRAC_BITS) + pqd_pkg::XAW'(511);
			nz_s2       <= (pqd_pkg::ZAW'(az) << pqd_pkg::FRAC_BITS) + pqd_pkg::ZAW'(255);
			cr_s2       <= cr_s1;
		end
	end

	// stage 3: scaled squares and reciprocal products
	always_ff @(posedge clk) begin
		if (en[2]) begin
			sx_s3 <= pqd_pkg::DW'(sqx_s2) * pqd_pkg::DW'(pqd_pkg::XY_SCALE_SQ);
			sy_s3 <= pqd_pkg::DW'(sqy_s2) * pqd_pkg::DW'(pqd_pkg::XY_SCALE_SQ);
			sz_s3 <= pqd_pkg::DW'(sqz_s2) * pqd_pkg::DW'(pqd_pkg::Z_SCALE_SQ);
			mx_s3 <= XPW'(nx_s2) * XPW'(pqd_pkg::RECIP_XY);
			my_s3 <= XPW'(ny_s2) * XPW'(pqd_pkg::RECIP_XY);
			mz_s3 <= ZPW'(nz_s2) * ZPW'(pqd_pkg::RECIP_Z);
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
			nz_s3 <= nz_s2;
			cr_s3 <= cr_s2;
		end
	end

	// stage 4: sum of squares and quotient estimates
	always_ff @(posedge clk) begin
		if (en[3]) begin
			sum_s4 <= sx_s3 + sy_s3 + sz_s3;
			q0x_s4 <= pqd_pkg::QDW'(mx_s3 >> pqd_pkg::RK);
			q0y_s4 <= pqd_pkg::QDW'(my_s3 >> pqd_pkg::RK);
			q0z_s4 <= pqd_pkg::QDW'(mz_s3 >> pqd_pkg::RK);
			sx_s4  <= sx_s3;
			sy_s4  <= sy_s3;
			sz_s4  <= sz_s3;
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			nz_s4  <= nz_s3;
			cr_s4  <= cr_s3;
		end
	end

	// stage 5: unit length test and quotient correction
	assign remx = (pqd_pkg::XAW + 1)'(nx_s4)
		- (pqd_pkg::XAW + 1)'(q0x_s4) * (pqd_pkg::XAW + 1)'(1023);
	assign remy = (pqd_pkg::XAW + 1)'(ny_s4)
		- (pqd_pkg::XAW + 1)'(q0y_s4) * (pqd_pkg::XAW + 1)'(1023);
	assign remz = (pqd_pkg::ZAW + 1)'(nz_s4)
		- (pqd_pkg::ZAW + 1)'(q0z_s4) * (pqd_pkg::ZAW + 1)'(511);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			norm_s5 <= sum_s4 >= pqd_pkg::DEN_SQ;
			diff_s5 <= pqd_pkg::DEN_SQ - sum_s4;
			qx_s5   <= q0x_s4 + pqd_pkg::QDW'(remx >= (pqd_pkg::XAW + 1)'(1023));
			qy_s5   <= q0y_s4 + pqd_pkg::QDW'(remy >= (pqd_pkg::XAW + 1)'(1023));
			qz_s5   <= q0z_s4 + pqd_pkg::QDW'(remz >= (pqd_pkg::ZAW + 1)'(511));
			sum_s5  <= sum_s4;
			sx_s5   <= sx_s4;
			sy_s5   <= sy_s4;
			sz_s5   <= sz_s4;
			cr_s5   <= cr_s4;
		end
	end

	// stage 6: starting remainders of the root units
	assign num_a = norm_s5 ? sx_s5 : diff_s5;
	assign den_a = norm_s5 ? sum_s5 : pqd_pkg::DEN_SQ;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ra_s6.rem <= (pqd_pkg::AW'(num_a) << SH) - pqd_pkg::AW'(den_a);
			ra_s6.par <= pqd_pkg::PW'(0) - pqd_pkg::PW'(den_a);
			ra_s6.den <= den_a;
			rb_s6.rem <= (pqd_pkg::AW'(sy_s5) << SH) - pqd_pkg::AW'(sum_s5);
			rb_s6.par <= pqd_pkg::PW'(0) - pqd_pkg::PW'(sum_s5);
			rb_s6.den <= sum_s5;
			rc_s6.rem <= (pqd_pkg::AW'(sz_s5) << SH) - pqd_pkg::AW'(sum_s5);
			rc_s6.par <= pqd_pkg::PW'(0) - pqd_pkg::PW'(sum_s5);
			rc_s6.den <= sum_s5;
			side_s6.key_time <= cr_s5.key_time;
			side_s6.last     <= cr_s5.last;
			side_s6.norm     <= norm_s5;
			side_s6.neg_x    <= cr_s5.neg_x;
			side_s6.neg_y    <= cr_s5.neg_y;
			side_s6.neg_z    <= cr_s5.neg_z;
			side_s6.qx       <= qx_s5;
			side_s6.qy       <= qy_s5;
			side_s6.qz       <= qz_s5;
		end
	end

	assign root_a = ra_s6;
	assign root_b = rb_s6;
	assign root_c = rc_s6;
	assign side   = side_s6;

endmodule

[sv/pqd_root.sv]
// pipelined rounded square root of a ratio, one result bit per stage
module pqd_root (
	input  logic                   clk,
	input  logic [pqd_pkg::QB-1:0] en,
	input  pqd_pkg::root_in_t      root_in,
	output logic [pqd_pkg::QB-1:0] root_q
);

	logic signed [pqd_pkg::AW-1:0] rem_s [pqd_pkg::QB];
	logic signed [pqd_pkg::PW-1:0] par_s [pqd_pkg::QB];
	logic [pqd_pkg::DW-1:0]        den_s [pqd_pkg::QB];
	logic [pqd_pkg::QB-1:0]        q_s   [pqd_pkg::QB];

	// remainder holds N - (2q-1)^2*den, par holds (2q-1)*den
	for (genvar k = 0; k < pqd_pkg::QB; k++) begin : g_stage
		localparam int B = pqd_pkg::FRAC_BITS - k;

		logic signed [pqd_pkg::AW-1:0] rem_i, dlt, trial;
		logic signed [pqd_pkg::PW-1:0] par_i;
		logic [pqd_pkg::DW-1:0]        den_i;
		logic [pqd_pkg::QB-1:0]        q_i;

		if (k == 0) begin : g_first
			assign rem_i = root_in.rem;
			assign par_i = root_in.par;
			assign den_i = root_in.den;
			assign q_i   = '0;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign par_i = par_s[k-1];
			assign den_i = den_s[k-1];
			assign q_i   = q_s[k-1];
		end

		// growth of (2q-1)^2*den when bit B is set
		assign dlt = (pqd_pkg::AW'(par_i) <<< (B + 2))
			+ $signed(pqd_pkg::AW'(den_i) << (2 * B + 2));
		assign trial = rem_i - dlt;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				den_s[k] <= den_i;
				if (!trial[pqd_pkg::AW-1]) begin
					rem_s[k] <= trial;
					par_s[k] <= par_i + $signed(pqd_pkg::PW'(den_i) << (B + 1));
					q_s[k]   <= q_i | (pqd_pkg::QB'(1) << B);
				end else begin
					rem_s[k] <= rem_i;
					par_s[k] <= par_i;
					q_s[k]   <= q_i;
				end
			end
		end
	end

	assign root_q = q_s[pqd_pkg::QB-1];

endmodule
